@@ design/uri_percent_unescape_unit_defines.svh @@
// Assertion macros used by upu_core.
// Each macro expects clk and rst_n in scope.
`ifndef URI_PERCENT_UNESCAPE_UNIT_DEFINES_SVH
`define URI_PERCENT_UNESCAPE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define UPU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("upu assertion failed");

`define UPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("upu assertion failed");

`else

`define UPU_ASSERT_SAME(lbl, ante, cons)

`define UPU_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ design/upu_pkg.sv @@
package upu_pkg;

  localparam int unsigned LEN_W       = 12;
  localparam int unsigned LEN_FIELD_MAX = 4095;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] PRINT_LO     = 8'd32;
  localparam logic [7:0] PRINT_HI     = 8'd126;

  // escape phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             done;
    logic             failed;
    logic [LEN_W-1:0] length;
  } res_t;

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
        d = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
        d = c - 8'h41 + 8'd10;
      end else if (c >= 8'h61 && c <= 8'h66) begin
        d = c - 8'h61 + 8'd10;
      end
      return d[3:0];
    end
  endfunction

endpackage

@@ design/upu_in_stage.sv @@
module upu_in_stage
  import upu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  item_t      in_item,
  output logic       in_stall,
  input  logic       advance,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  load;

  assign in_stall  = valid_r && !advance;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ design/upu_core.sv @@
`include "uri_percent_unescape_unit_defines.svh"

module upu_core
  import upu_pkg::*;
#(
  parameter int unsigned MAX_LEN = 4095
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  output logic  produce,
  output res_t  res
);

  localparam int unsigned CAP_INT = (MAX_LEN < LEN_FIELD_MAX) ? MAX_LEN : LEN_FIELD_MAX;
  localparam logic [LEN_W-1:0] COUNT_CAP = CAP_INT[LEN_W-1:0];

  phase_t           phase_r, phase_nxt;
  logic [3:0]       high_r, high_nxt;
  logic [LEN_W-1:0] count_r, count_nxt;
  logic             err_r, err_nxt;

  logic       emit;
  logic       range_bad;
  logic [7:0] value;
  logic [3:0] digit;

  assign digit = hex_digit(item.data);

  // decode of the current byte
  always_comb begin
    emit      = 1'b0;
    range_bad = 1'b0;
    value     = 8'd0;
    if (!err_r) begin
      case (phase_r)
        PH_HIGH: begin
          value = 8'd0;
        end
        PH_LOW: begin
          value = {high_r, digit};
          if (value < PRINT_LO || value > PRINT_HI) begin
            range_bad = 1'b1;
          end else begin
            emit = 1'b1;
          end
        end
        default: begin
          if (item.data != CHAR_PERCENT) begin
            value = item.data;
            emit  = 1'b1;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    if (!err_r) begin
      case (phase_r)
        PH_HIGH: begin
          high_nxt  = digit;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          phase_nxt = PH_NORMAL;
          err_nxt   = range_bad;
        end
        default: begin
          phase_nxt = (item.data == CHAR_PERCENT) ? PH_HIGH : PH_NORMAL;
        end
      endcase
      if (emit && count_r < COUNT_CAP) begin
        count_nxt = count_r + 1'b1;
      end
      // escape cut short by end of string
      if (item.last && !err_nxt && phase_nxt != PH_NORMAL) begin
        err_nxt = 1'b1;
      end
    end
  end

  // result fields
  always_comb begin
    produce        = emit || item.last;
    res.out_byte   = emit ? value : 8'd0;
    res.byte_valid = emit;
    res.done       = item.last;
    res.failed     = item.last && err_nxt;
    res.length     = (item.last && !err_nxt) ? count_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      high_r  <= 4'd0;
      count_r <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      if (item.last) begin
        phase_r <= PH_NORMAL;
        high_r  <= 4'd0;
        count_r <= '0;
        err_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        high_r  <= high_nxt;
        count_r <= count_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  `UPU_ASSERT_NEXT(a_end_clears, fire && item.last, phase_r == PH_NORMAL && count_r == '0 && !err_r)
  `UPU_ASSERT_SAME(a_count_cap, 1'b1, count_r <= COUNT_CAP)
  `UPU_ASSERT_SAME(a_err_no_escape, err_r, phase_r == PH_NORMAL)

endmodule

@@ design/upu_out_stage.sv @@
module upu_out_stage
  import upu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic load,
  input  res_t res_in,
  output logic ready,
  output logic out_valid,
  input  logic out_stall,
  output res_t res_out
);

  logic valid_r, valid_nxt;
  res_t res_r;
  logic drain;

  assign drain     = valid_r && !out_stall;
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (drain ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

@@ design/uri_percent_unescape_unit.sv @@
// Percent-decoder for a byte stream, one character per transfer with a
// last-byte flag. Ordinary bytes pass straight through; '%' followed by two
// hex digits becomes one byte (a non-hex digit reads as 0). A decoded value
// outside printable ASCII 32..126, or an escape cut off by the end of the
// string, marks the string failed: nothing more is emitted until the last
// byte, whose result carries done, failed=1 and length 0. Otherwise the
// last byte's result carries the decoded length, saturating at
// min(MAX_LEN, 4095). Bytes already emitted for a failed string must be
// dropped by the consumer. Throughput is one input transfer per clock while
// the result channel is not stalled; an input transfer passes through the
// input register, the phase machine's decode and the result register.
// A byte that neither decodes a character nor ends the string (a '%' or a
// first hex digit) yields no result transfer.
module uri_percent_unescape_unit
  import upu_pkg::*;
#(
  parameter int unsigned MAX_LEN = 4095
) (
  input  logic             clk,
  input  logic             rst_n,
  // input channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_byte,
  input  logic             in_last_byte,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             out_byte_valid,
  output logic             out_done_res,
  output logic             out_failed,
  output logic [LEN_W-1:0] out_decoded_length
);

  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  out_ready;
  logic  fire;
  logic  produce;
  res_t  res;
  res_t  res_q;

  assign in_item.data = in_byte;
  assign in_item.last = in_last_byte;

  // An item leaves the input register when the result register can take
  // whatever it produces.
  assign fire = item_valid && out_ready;

  upu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .advance    (out_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  // phase machine, escape decode, counter and error flag
  upu_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .item    (item),
    .produce (produce),
    .res     (res)
  );

  upu_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && produce),
    .res_in    (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res_q)
  );

  assign out_byte           = res_q.out_byte;
  assign out_byte_valid     = res_q.byte_valid;
  assign out_done_res       = res_q.done;
  assign out_failed         = res_q.failed;
  assign out_decoded_length = res_q.length;

endmodule
